FILE: design/bydc_pkg.sv
package bydc_pkg;

    localparam int MAX_PERIODS = 64;
    localparam int AMOUNT_BITS = 40;
    localparam int PIDX_BITS   = $clog2(MAX_PERIODS);
    localparam int PCNT_BITS   = $clog2(MAX_PERIODS + 1);

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_CONV  = 3'd1;
    localparam logic [2:0] ST_ZERO_DER = 3'd2;
    localparam logic [2:0] ST_ZERO_PRC = 3'd3;
    localparam logic [2:0] ST_TOO_MANY = 3'd4;

    localparam logic [0:0] REG_TOL   = 1'd0;
    localparam logic [0:0] REG_LIMIT = 1'd1;

    typedef struct packed {
        logic [AMOUNT_BITS-1:0] bond_price_in;
        logic [AMOUNT_BITS-1:0] cash_flow_amount;
        logic                   last_period;
    } t_req;

    typedef struct packed {
        logic signed [31:0] yield_rate;
        logic [31:0]        macaulay_duration;
        logic [39:0]        bond_convexity;
        logic [2:0]         result_status;
        logic [7:0]         steps_used;
    } t_res;

    // divider control
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
        logic [5:0]  shift;
        logic [63:0] cap;
    } t_div_cmd;

endpackage

FILE: design/bydc_mul.sv
// floor(a*b / 2^30) saturated at cap, four 32x32 partial products over cycles
module bydc_mul
    import bydc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    input  logic [63:0] i_cap,
    output logic        o_done,
    output logic [63:0] o_res
);
    logic [2:0]   r_ph;
    logic [63:0]  r_a, r_b, r_cap, r_res;
    logic [127:0] r_acc;
    logic         r_done;
    logic [31:0]  w_x, w_y;
    logic [63:0]  w_p;
    logic [127:0] w_sh;

    always_comb begin
        case (r_ph)
            3'd1: begin w_x = r_a[31:0];  w_y = r_b[31:0];  w_sh = 128'(w_p); end
            3'd2: begin w_x = r_a[31:0];  w_y = r_b[63:32]; w_sh = 128'(w_p) << 32; end
            3'd3: begin w_x = r_a[63:32]; w_y = r_b[31:0];  w_sh = 128'(w_p) << 32; end
            3'd4: begin w_x = r_a[63:32]; w_y = r_b[63:32]; w_sh = 128'(w_p) << 64; end
            default: begin w_x = '0; w_y = '0; w_sh = '0; end
        endcase
    end
    assign w_p = 64'(w_x) * 64'(w_y);

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_ph <= '0;
        end else if (i_start) begin
            r_a <= i_a; r_b <= i_b; r_cap <= i_cap; r_acc <= '0; r_ph <= 3'd1;
        end else if (r_ph >= 3'd1 && r_ph <= 3'd4) begin
            r_acc <= r_acc + w_sh;
            r_ph  <= r_ph + 3'd1;
        end else if (r_ph == 3'd5) begin
            if (r_acc[127:94] != '0 || r_acc[93:30] > r_cap) r_res <= r_cap;
            else r_res <= r_acc[93:30];
            r_done <= 1'b1;
            r_ph   <= '0;
        end
    end
    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

FILE: design/bydc_div.sv
// floor(n*2^sh/d) saturated at cap, restoring, one quotient bit a cycle
module bydc_div
    import bydc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_cmd    i_cmd,
    output logic        o_done,
    output logic [63:0] o_res
);
    logic [6:0]   r_cnt, r_end;
    logic         r_busy, r_done, r_ovf;
    logic [63:0]  r_num;
    logic [63:0]  r_den, r_cap, r_q, r_res;
    logic [63:0]  r_rem;
    logic [64:0]  w_try;
    logic         w_bit;

    assign w_try = {r_rem, r_num[63]};
    assign w_bit = (w_try >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.start) begin
            r_num  <= i_cmd.num;
            r_den  <= i_cmd.den;
            r_cap  <= i_cmd.cap;
            r_rem  <= '0;
            r_q    <= '0;
            r_ovf  <= 1'b0;
            r_cnt  <= 7'd0;
            r_end  <= 7'd64 + 7'(i_cmd.shift);
            r_busy <= 1'b1;
        end else if (r_busy) begin
            // numerator bits then shift zero bits, a bit leaving the quotient saturates
            if (r_cnt < r_end) begin
                if (w_bit) r_rem <= 64'(w_try - {1'b0, r_den});
                else r_rem <= w_try[63:0];
                r_q   <= {r_q[62:0], w_bit};
                r_ovf <= r_ovf | r_q[63];
                r_num <= {r_num[62:0], 1'b0};
                r_cnt <= r_cnt + 7'd1;
            end else begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
                r_res  <= (r_ovf || r_q > r_cap) ? r_cap : r_q;
            end
        end
    end
    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

FILE: design/bond_yield_duration_convexity.sv
// input: one request per cycle while collecting; after the last request Newton passes
// run over the n stored periods up to the closing pass, then duration and convexity
// are computed; a zero price goes straight to the result
// throughput: one bond at a time, stall held high from the last request to the result
// the shared 32x32 product unit and the bit-serial divider set the pace
// reset: synchronous active low; tolerance 1, step limit 32, store count cleared
module bond_yield_duration_convexity
    import bydc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_req        i_req,
    output logic        o_valid,
    input  logic        i_stall,
    output t_res        o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic [4:0] S_IN = 5'd0, S_EV0 = 5'd1, S_EVR = 5'd2, S_M1 = 5'd3,
        S_M2 = 5'd4, S_CHK = 5'd5, S_DV = 5'd6, S_UPD = 5'd7, S_V = 5'd8,
        S_T0 = 5'd9, S_RD = 5'd10, S_T1 = 5'd11, S_T2 = 5'd12, S_S2A = 5'd13,
        S_S2B = 5'd14, S_DUR = 5'd15, S_CVX = 5'd16, S_OUT = 5'd17, S_MW = 5'd18,
        S_RW = 5'd19;

    logic [4:0]             r_st;
    logic [AMOUNT_BITS-1:0] r_mem [MAX_PERIODS];
    logic [AMOUNT_BITS-1:0] r_rd;
    logic [AMOUNT_BITS-1:0] r_price;
    logic [PCNT_BITS-1:0]   r_cnt;
    logic [PIDX_BITS-1:0]   r_t;
    logic                   r_ovf;
    logic signed [31:0]     r_rate;
    logic signed [63:0]     r_acc, r_d, r_tmp;
    logic [63:0]            r_v, r_w, r_s1, r_s2, r_term;
    logic [7:0]             r_steps;
    logic [15:0]            r_tol;
    logic [7:0]             r_lim;
    logic [2:0]             r_status;
    logic                   r_last;
    t_res                   r_res;

    logic        w_mstart, w_mdone;
    logic [63:0] w_ma, w_mb, w_mcap, w_mres;
    t_div_cmd    w_dcmd;
    logic        w_ddone;
    logic [63:0] w_dres;
    logic        r_mneg;
    logic [4:0]  r_ret;
    logic        r_mgo;
    logic [63:0] r_ma, r_mb, r_mcap;
    logic        r_dgo;
    logic [63:0] r_dn, r_dd, r_dcap;
    logic [5:0]  r_dsh;

    logic signed [63:0] w_g;
    logic [63:0]        w_mf, w_md;
    logic signed [64:0] w_nr;
    logic               w_cfg_wr;

    bydc_mul u_mul (.i_clk, .i_rst_n, .i_start(w_mstart), .i_a(w_ma), .i_b(w_mb),
        .i_cap(w_mcap), .o_done(w_mdone), .o_res(w_mres));
    bydc_div u_div (.i_clk, .i_rst_n, .i_cmd(w_dcmd), .o_done(w_ddone), .o_res(w_dres));

    assign w_mstart = r_mgo;
    assign w_ma = r_ma; assign w_mb = r_mb; assign w_mcap = r_mcap;
    assign w_dcmd = '{start: r_dgo, num: r_dn, den: r_dd, shift: r_dsh, cap: r_dcap};

    assign w_g  = 64'sd1073741824 + 64'(r_rate);
    assign w_mf = r_acc[63] ? 64'(-r_acc) : 64'(r_acc);
    assign w_md = r_d[63] ? 64'(-r_d) : 64'(r_d);

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_LIMIT) ? {24'd0, r_lim} : {16'd0, r_tol};

    assign o_stall = (r_st != S_IN);
    assign o_valid = (r_st == S_OUT);
    assign o_res   = r_res;

    // signed product helper: magnitudes to the unit, sign applied on return
    function automatic logic [63:0] mag(input logic signed [63:0] x);
        mag = x[63] ? 64'(-x) : 64'(x);
    endfunction

    always_ff @(posedge i_clk) begin
        if (r_st == S_IN && i_valid && r_cnt < PCNT_BITS'(MAX_PERIODS))
            r_mem[r_cnt[PIDX_BITS-1:0]] <= i_req.cash_flow_amount;
        r_rd <= r_mem[r_t];
    end

    always_ff @(posedge i_clk) begin
        r_mgo <= 1'b0;
        r_dgo <= 1'b0;
        if (!i_rst_n) begin
            r_st <= S_IN; r_cnt <= '0; r_ovf <= 1'b0; r_price <= '0;
            r_tol <= 16'd1; r_lim <= 8'd32; r_rate <= '0; r_steps <= '0;
        end else begin
            if (w_cfg_wr) begin
                if (paddr[2] == REG_TOL) r_tol <= pwdata[15:0];
                else r_lim <= pwdata[7:0];
            end
            case (r_st)
                S_IN: if (i_valid) begin
                    if (r_cnt == '0 && !r_ovf) r_price <= i_req.bond_price_in;
                    if (r_cnt < PCNT_BITS'(MAX_PERIODS)) r_cnt <= r_cnt + 1'b1;
                    else r_ovf <= 1'b1;
                    if (i_req.last_period) begin
                        r_rate <= '0; r_steps <= '0;
                        if ((r_cnt == '0 && !r_ovf) ? (i_req.bond_price_in == '0)
                                                     : (r_price == '0)) begin
                            r_status <= ST_ZERO_PRC; r_st <= S_OUT;
                            r_res <= '{yield_rate: '0, macaulay_duration: '0,
                                bond_convexity: '0, result_status: ST_ZERO_PRC,
                                steps_used: '0};
                        end else r_st <= S_EV0;
                    end
                end
                S_EV0: begin
                    r_acc <= 64'(r_price); r_d <= '0; r_t <= '0; r_st <= S_EVR;
                end
                S_EVR: begin
                    // d = d*g + acc
                    r_mneg <= r_d[63] ^ w_g[63]; r_ma <= mag(r_d); r_mb <= mag(w_g);
                    r_mcap <= (r_d[63] ^ w_g[63]) ? 64'h8000000000000000
                                                  : 64'h7fffffffffffffff;
                    r_mgo <= 1'b1; r_ret <= S_M1; r_st <= S_MW;
                end
                S_M1: begin
                    r_tmp <= r_acc;
                    r_d <= sat_add(r_tmp, r_acc);
                    r_mneg <= r_acc[63] ^ w_g[63]; r_ma <= mag(r_acc); r_mb <= mag(w_g);
                    r_mcap <= (r_acc[63] ^ w_g[63]) ? 64'h8000000000000000
                                                    : 64'h7fffffffffffffff;
                    r_mgo <= 1'b1; r_ret <= S_M2; r_st <= S_MW;
                end
                S_M2: begin
                    r_acc <= sat_add(r_tmp, -64'(r_rd));
                    if (r_t == PIDX_BITS'(r_cnt - 1'b1)) r_st <= S_CHK;
                    else begin r_t <= r_t + 1'b1; r_st <= S_EVR; end
                end
                S_CHK: begin
                    if (w_mf <= 64'(r_tol)) begin
                        r_status <= r_ovf ? ST_TOO_MANY : ST_OK; r_st <= S_V;
                    end else if (r_steps >= r_lim) begin
                        r_status <= ST_NO_CONV; r_st <= S_V;
                    end else if (r_d == '0) begin
                        r_status <= ST_ZERO_DER; r_st <= S_V;
                    end else begin
                        r_dn <= w_mf; r_dd <= w_md; r_dsh <= 6'd30;
                        r_dcap <= 64'h400000000; r_dgo <= 1'b1; r_st <= S_DV;
                    end
                end
                S_DV: if (w_ddone) r_st <= S_UPD;
                S_UPD: begin
                    if (w_nr > 65'sd2147483647) r_rate <= 32'sh7fffffff;
                    else if (w_nr < -65'sd2147483648) r_rate <= 32'sh80000000;
                    else r_rate <= w_nr[31:0];
                    r_steps <= r_steps + 8'd1;
                    r_st <= S_EV0;
                end
                S_V: begin
                    r_s1 <= '0; r_s2 <= '0; r_t <= '0;
                    if (w_g > 0) begin
                        r_dn <= 64'd1073741824; r_dd <= 64'(w_g); r_dsh <= 6'd30;
                        r_dcap <= '1; r_dgo <= 1'b1; r_st <= S_T0;
                    end else begin
                        r_res <= '{yield_rate: r_rate, macaulay_duration: '0,
                            bond_convexity: '0, result_status: r_status,
                            steps_used: r_steps};
                        r_st <= S_OUT;
                    end
                end
                S_T0: if (w_ddone) begin
                    r_v <= w_dres; r_w <= w_dres; r_st <= S_RD;
                end
                S_RD: begin
                    r_ma <= 64'(r_rd); r_mb <= r_w; r_mcap <= '1; r_mneg <= 1'b0;
                    r_mgo <= 1'b1; r_ret <= S_T1; r_st <= S_MW;
                end
                S_T1: begin
                    r_term <= umul_k(r_tmp, 64'(r_t) + 64'd1);
                    r_ma <= r_w; r_mb <= r_v; r_mcap <= '1;
                    r_mgo <= 1'b1; r_ret <= S_T2; r_st <= S_MW;
                end
                S_T2: begin
                    r_w  <= r_tmp;
                    r_s1 <= uadd(r_s1, r_term);
                    r_s2 <= uadd(r_s2, umul_k(r_term, 64'(r_t) + 64'd2));
                    if (r_t == PIDX_BITS'(r_cnt - 1'b1)) begin
                        r_st <= S_S2A;
                    end else begin
                        r_t <= r_t + 1'b1; r_st <= S_RW;
                    end
                end
                // next flow read out of the store
                S_RW: r_st <= S_RD;
                S_S2A: begin
                    r_ma <= r_s2; r_mb <= r_v; r_mcap <= '1;
                    r_mgo <= 1'b1; r_ret <= S_S2B; r_st <= S_MW;
                end
                S_S2B: begin
                    r_s2 <= r_tmp;
                    if (r_last) begin
                        r_dn <= r_s1; r_dd <= 64'(r_price); r_dsh <= 6'd24;
                        r_dcap <= 64'hffffffff; r_dgo <= 1'b1; r_st <= S_DUR;
                    end else begin
                        r_ma <= r_tmp; r_mb <= r_v; r_mcap <= '1;
                        r_mgo <= 1'b1; r_ret <= S_S2B; r_st <= S_MW;
                    end
                end
                S_DUR: if (w_ddone) begin
                    r_res.macaulay_duration <= w_dres[31:0];
                    r_dn <= r_s2; r_dd <= 64'(r_price); r_dsh <= 6'd24;
                    r_dcap <= 64'hffffffffff; r_dgo <= 1'b1; r_st <= S_CVX;
                end
                S_CVX: if (w_ddone) begin
                    r_res.bond_convexity <= w_dres[39:0];
                    r_res.yield_rate <= r_rate;
                    r_res.result_status <= r_status;
                    r_res.steps_used <= r_steps;
                    r_st <= S_OUT;
                end
                S_MW: if (w_mdone) begin
                    r_tmp <= r_mneg ? -$signed(w_mres) : $signed(w_mres);
                    r_st <= r_ret;
                end
                S_OUT: if (!i_stall) begin
                    r_cnt <= '0; r_ovf <= 1'b0; r_st <= S_IN;
                end
                default: r_st <= S_IN;
            endcase
        end
    end

    // second multiply of s2 tracked with r_last
    always_ff @(posedge i_clk) begin
        if (r_st == S_S2A) r_last <= 1'b0;
        else if (r_st == S_S2B) r_last <= 1'b1;
    end

    // mf sign of delta
    always_comb begin
        if (r_acc[63] != r_d[63]) w_nr = 65'(r_rate) + 65'(w_dres);
        else w_nr = 65'(r_rate) - 65'(w_dres);
    end

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh07fffffffffffffff) sat_add = 64'sh7fffffffffffffff;
        else if (s < -65'sh08000000000000000) sat_add = 64'sh8000000000000000;
        else sat_add = s[63:0];
    endfunction

    function automatic logic [63:0] uadd(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = 65'(a) + 65'(b);
        uadd = s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] umul_k(input logic [63:0] x, input logic [63:0] k);
        logic [71:0] p;
        p = 72'(x) * 72'(k[7:0]);
        umul_k = (p[71:64] != '0) ? '1 : p[63:0];
    endfunction
endmodule
